### design/mpd_pkg.sv
// Shared types and constants for the MessagePack subset token decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mpd_pkg;

  // Header bytes of the supported MessagePack subset
  localparam logic [7:0] HB_FIXINT_HI  = 8'h7F;
  localparam logic [7:0] HB_NIL        = 8'hC0;
  localparam logic [7:0] HB_BIN8       = 8'hC4;
  localparam logic [7:0] HB_BIN16      = 8'hC5;
  localparam logic [7:0] HB_BIN32      = 8'hC6;
  localparam logic [7:0] HB_UINT8      = 8'hCC;
  localparam logic [7:0] HB_UINT16     = 8'hCD;
  localparam logic [7:0] HB_UINT32     = 8'hCE;
  localparam logic [7:0] HB_STR8       = 8'hD9;
  localparam logic [7:0] HB_ARRAY16    = 8'hDC;
  localparam logic [7:0] HB_FIXARR_LO  = 8'h90;
  localparam logic [7:0] HB_FIXARR_HI  = 8'h9F;
  localparam logic [7:0] HB_FIXSTR_LO  = 8'hA0;
  localparam logic [7:0] HB_FIXSTR_HI  = 8'hBF;

  // Token kind codes on the result channel
  localparam logic [3:0] K_PENDING = 4'd0;
  localparam logic [3:0] K_UINT    = 4'd1;
  localparam logic [3:0] K_NIL     = 4'd2;
  localparam logic [3:0] K_BIN     = 4'd3;
  localparam logic [3:0] K_STR     = 4'd4;
  localparam logic [3:0] K_ARR     = 4'd5;
  localparam logic [3:0] K_PAYLOAD = 4'd6;
  localparam logic [3:0] K_BAD     = 4'd7;
  localparam logic [3:0] K_TRUNC   = 4'd8;

  // Parser phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HDR     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_SKIP    = 4'b1000
  } phase_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  hdr_left;
    logic [2:0]  pending_kind;
    logic [31:0] acc;
    logic [31:0] payload_left;
  } state_t;

  // One result transaction
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [7:0]  pbyte;
    logic        plast;
  } result_t;

  // Registered input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_stage_t;

  localparam state_t STATE_IDLE = '{phase: PH_IDLE, hdr_left: 3'd0, pending_kind: 3'd0,
                                    acc: 32'd0, payload_left: 32'd0};

endpackage

`default_nettype wire

### design/msgpack_subset_token_decoder.sv
// Top level of the MessagePack subset token decoder.
// Depends on mpd_pkg, mpd_in_stage and mpd_step.
`default_nettype none

// The decoder takes one byte of a message per cycle and returns exactly one
// result transaction for each byte: a finished token (uint, nil, bin/str/array
// header with its value, length or count), a payload byte with its last flag,
// an error (bad header, truncated message), or a pending marker while a header
// is still being collected or an errored message is skipped. A new byte can be
// taken in every cycle in which no held result is stalled; each byte passes an
// input register and then a result register before its result is on the outputs.
// The parser state updates in the same cycle the byte moves from the input
// register into the result register, which sets the one-byte-per-cycle rate.
module msgpack_subset_token_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_in_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [31:0] token_value,
  output logic [7:0]  payload_byte,
  output logic        payload_last
);
  import mpd_pkg::*;

  logic      advance;
  in_stage_t stage;
  state_t    state;
  state_t    state_next;
  result_t   res_next;
  result_t   res;
  logic      res_valid;

  // Move the whole pipeline unless a held result is stalled
  assign advance  = !(res_valid && out_stall);
  assign in_stall = !advance;

  mpd_in_stage u_in (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .in_valid        (in_valid),
    .data_byte       (data_byte),
    .last_in_message (last_in_message),
    .stage           (stage)
  );

  mpd_step u_step (
    .cur  (state),
    .data (stage.data),
    .last (stage.last),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Update parser state as each byte retires
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
    end else if (advance && stage.valid) begin
      state <= state_next;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage.valid;
    end
    if (advance && stage.valid) begin
      res <= res_next;
    end
  end

  assign out_valid    = res_valid;
  assign token_kind   = res.kind;
  assign token_value  = res.value;
  assign payload_byte = res.pbyte;
  assign payload_last = res.plast;

endmodule

`default_nettype wire

### design/mpd_in_stage.sv
// Input register of the token decoder: captures one byte transaction.
// Depends on mpd_pkg.
`default_nettype none

module mpd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic [7:0]         data_byte,
  input  logic               last_in_message,
  output mpd_pkg::in_stage_t stage
);
  import mpd_pkg::*;

  in_stage_t stage_q;

  // Load a new byte whenever the pipeline moves
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_q.valid <= 1'b0;
    end else if (advance) begin
      stage_q.valid <= in_valid;
    end
    if (advance) begin
      stage_q.data <= data_byte;
      stage_q.last <= last_in_message;
    end
  end

  assign stage = stage_q;

endmodule

`default_nettype wire

### design/mpd_step.sv
// Per-byte decode logic: next parser state and the result for one byte.
// Purely combinational; depends on mpd_pkg.
`default_nettype none

module mpd_step (
  input  mpd_pkg::state_t  cur,
  input  logic [7:0]       data,
  input  logic             last,
  output mpd_pkg::state_t  nxt,
  output mpd_pkg::result_t res
);
  import mpd_pkg::*;

  typedef struct packed {
    state_t  st;
    result_t res;
  } step_t;

  // Close a header: bin/str with a nonzero length go on to payload unless the message ends
  function automatic step_t finish_hdr(logic [3:0] kind, logic [31:0] value, logic lst);
    step_t s;
    s.st  = STATE_IDLE;
    s.res = '0;
    if ((kind == K_BIN || kind == K_STR) && value != 32'd0) begin
      if (lst) begin
        s.res.kind = K_TRUNC;
      end else begin
        s.st.phase        = PH_PAYLOAD;
        s.st.payload_left = value;
        s.res.kind        = kind;
        s.res.value       = value;
      end
    end else begin
      s.res.kind  = kind;
      s.res.value = value;
    end
    return s;
  endfunction

  // Open a multi-byte header
  function automatic step_t start_hdr(logic [3:0] kind, logic [2:0] nbytes, logic lst);
    step_t s;
    s.st  = STATE_IDLE;
    s.res = '0;
    if (lst) begin
      s.res.kind = K_TRUNC;
    end else begin
      s.st.phase        = PH_HDR;
      s.st.hdr_left     = nbytes;
      s.st.pending_kind = kind[2:0];
      s.res.kind        = K_PENDING;
    end
    return s;
  endfunction

  step_t       s;
  logic [31:0] acc_new;

  assign acc_new = {cur.acc[23:0], data};

  always_comb begin
    s.st  = cur;
    s.res = '0;
    unique case (cur.phase)
      PH_HDR: begin
        if (cur.hdr_left <= 3'd1) begin
          s = finish_hdr({1'b0, cur.pending_kind}, acc_new, last);
        end else if (last) begin
          s.st       = STATE_IDLE;
          s.res.kind = K_TRUNC;
        end else begin
          s.st.hdr_left = cur.hdr_left - 3'd1;
          s.st.acc      = acc_new;
          s.res.kind    = K_PENDING;
        end
      end
      PH_PAYLOAD: begin
        if (cur.payload_left <= 32'd1) begin
          s.st        = STATE_IDLE;
          s.res.kind  = K_PAYLOAD;
          s.res.pbyte = data;
          s.res.plast = 1'b1;
        end else if (last) begin
          s.st       = STATE_IDLE;
          s.res.kind = K_TRUNC;
        end else begin
          s.st.payload_left = cur.payload_left - 32'd1;
          s.res.kind        = K_PAYLOAD;
          s.res.pbyte       = data;
        end
      end
      PH_SKIP: begin
        // Drop bytes until the message ends
        if (last) begin
          s.st = STATE_IDLE;
        end
        s.res.kind = K_PENDING;
      end
      PH_IDLE: begin
        unique case (data) inside
          [8'h00:HB_FIXINT_HI]:         s = finish_hdr(K_UINT, {24'd0, data}, last);
          HB_NIL:                       s = finish_hdr(K_NIL, 32'd0, last);
          HB_UINT8:                     s = start_hdr(K_UINT, 3'd1, last);
          HB_UINT16:                    s = start_hdr(K_UINT, 3'd2, last);
          HB_UINT32:                    s = start_hdr(K_UINT, 3'd4, last);
          HB_BIN8:                      s = start_hdr(K_BIN, 3'd1, last);
          HB_BIN16:                     s = start_hdr(K_BIN, 3'd2, last);
          HB_BIN32:                     s = start_hdr(K_BIN, 3'd4, last);
          [HB_FIXSTR_LO:HB_FIXSTR_HI]:  s = finish_hdr(K_STR, {27'd0, data[4:0]}, last);
          HB_STR8:                      s = start_hdr(K_STR, 3'd1, last);
          [HB_FIXARR_LO:HB_FIXARR_HI]:  s = finish_hdr(K_ARR, {28'd0, data[3:0]}, last);
          HB_ARRAY16:                   s = start_hdr(K_ARR, 3'd2, last);
          default: begin
            // Unknown header: report it, skip the rest of the message
            s.st = STATE_IDLE;
            if (!last) begin
              s.st.phase = PH_SKIP;
            end
            s.res.kind  = K_BAD;
            s.res.value = {24'd0, data};
          end
        endcase
      end
      default: begin
        s.st = STATE_IDLE;
      end
    endcase
  end

  assign nxt = s.st;
  assign res = s.res;

endmodule

`default_nettype wire

### design/mpd_checker.sv
// Port-level checks for the token decoder, bound to its top level.
// Depends on mpd_pkg and msgpack_subset_token_decoder.
`default_nettype none

module mpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        last_in_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  token_kind,
  input logic [31:0] token_value,
  input logic [7:0]  payload_byte,
  input logic        payload_last
);
  import mpd_pkg::*;

  // A stalled input transaction holds its byte
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(last_in_message))
    else $error("stalled input changed");

  // A stalled result holds its kind and value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(token_value))
    else $error("stalled result changed");

  // Last flag only on a payload byte
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_last |-> token_kind == K_PAYLOAD)
    else $error("payload_last outside payload");

  // Payload byte is zero outside payload transactions
  a_pbyte: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != K_PAYLOAD |-> payload_byte == 8'd0)
    else $error("stray payload byte");

  // Kinds without a value carry zero
  a_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == K_PENDING || token_kind == K_PAYLOAD ||
                  token_kind == K_NIL || token_kind == K_TRUNC) |-> token_value == 32'd0)
    else $error("nonzero value on a valueless kind");

endmodule

bind msgpack_subset_token_decoder mpd_checker u_mpd_checker (.*);

`default_nettype wire

### dv/msgpack_subset_token_decoder_tb.sv
// Self-checking testbench for msgpack_subset_token_decoder: directed and random messages,
// with a scoreboard that decodes each accepted byte and checks the result transactions.
// Depends on mpd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module msgpack_subset_token_decoder_tb;
  import mpd_pkg::*;

  localparam int RANDOM_BYTES = 1500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Decode accepted bytes into expected tokens and compare them with the results
  class token_scoreboard;
    phase_t      phase;
    logic [2:0]  hdr_left;
    logic [2:0]  pend_kind;
    logic [31:0] acc;
    logic [31:0] pay_left;
    result_t     tokens_due[$];
    int          mismatches;

    function new();
      mismatches = 0;
      go_idle();
    endfunction

    function void go_idle();
      phase     = PH_IDLE;
      hdr_left  = '0;
      pend_kind = '0;
      acc       = '0;
      pay_left  = '0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    // Report a finished header; a nonzero bin/str length opens a payload unless the message ends
    function result_t close_header(logic [3:0] kind, logic [31:0] v, logic l);
      result_t r;
      r = '0;
      go_idle();
      if ((kind == K_BIN || kind == K_STR) && v != 0) begin
        if (l) begin
          r.kind = K_TRUNC;
          return r;
        end
        phase    = PH_PAYLOAD;
        pay_left = v;
      end
      r.kind  = kind;
      r.value = v;
      return r;
    endfunction

    // Begin collecting a multi-byte big-endian header
    function result_t open_header(logic [3:0] kind, logic [2:0] n, logic l);
      result_t r;
      r = '0;
      if (l) begin
        go_idle();
        r.kind = K_TRUNC;
        return r;
      end
      phase     = PH_HDR;
      hdr_left  = n;
      pend_kind = kind[2:0];
      acc       = '0;
      r.kind    = K_PENDING;
      return r;
    endfunction

    function void decode_byte(logic [7:0] b, logic l);
      result_t r;
      r = '0;
      case (phase)
        PH_HDR: begin
          acc = {acc[23:0], b};
          if (hdr_left <= 3'd1) begin
            r = close_header({1'b0, pend_kind}, acc, l);
          end else if (l) begin
            go_idle();
            r.kind = K_TRUNC;
          end else begin
            hdr_left = hdr_left - 3'd1;
            r.kind   = K_PENDING;
          end
        end
        PH_PAYLOAD: begin
          if (pay_left <= 32'd1) begin
            go_idle();
            r.kind  = K_PAYLOAD;
            r.pbyte = b;
            r.plast = 1'b1;
          end else if (l) begin
            go_idle();
            r.kind = K_TRUNC;
          end else begin
            pay_left = pay_left - 32'd1;
            r.kind   = K_PAYLOAD;
            r.pbyte  = b;
          end
        end
        PH_SKIP: begin
          if (l) go_idle();
          r.kind = K_PENDING;
        end
        default: begin
          if (b <= HB_FIXINT_HI) r = close_header(K_UINT, {24'd0, b}, l);
          else if (b == HB_NIL) r = close_header(K_NIL, 32'd0, l);
          else if (b == HB_UINT8) r = open_header(K_UINT, 3'd1, l);
          else if (b == HB_UINT16) r = open_header(K_UINT, 3'd2, l);
          else if (b == HB_UINT32) r = open_header(K_UINT, 3'd4, l);
          else if (b == HB_BIN8) r = open_header(K_BIN, 3'd1, l);
          else if (b == HB_BIN16) r = open_header(K_BIN, 3'd2, l);
          else if (b == HB_BIN32) r = open_header(K_BIN, 3'd4, l);
          else if (b >= HB_FIXSTR_LO && b <= HB_FIXSTR_HI)
            r = close_header(K_STR, {27'd0, b[4:0]}, l);
          else if (b == HB_STR8) r = open_header(K_STR, 3'd1, l);
          else if (b >= HB_FIXARR_LO && b <= HB_FIXARR_HI)
            r = close_header(K_ARR, {28'd0, b[3:0]}, l);
          else if (b == HB_ARRAY16) r = open_header(K_ARR, 3'd2, l);
          else begin
            // Unknown header: skip the rest of the message
            go_idle();
            if (!l) phase = PH_SKIP;
            r.kind  = K_BAD;
            r.value = {24'd0, b};
          end
        end
      endcase
      tokens_due = {tokens_due, r};
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_token(result_t got);
      result_t want;
      if (tokens_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got kind %0d value %h byte %h last %b",
                 $time, got.kind, got.value, got.pbyte, got.plast);
        mismatches++;
        return;
      end
      want = tokens_due.pop_front();
      field_check("token_kind", {28'd0, want.kind}, {28'd0, got.kind});
      field_check("token_value", want.value, got.value);
      field_check("payload_byte", {24'd0, want.pbyte}, {24'd0, got.pbyte});
      field_check("payload_last", {31'd0, want.plast}, {31'd0, got.plast});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_in_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [31:0] token_value;
  logic [7:0]  payload_byte;
  logic        payload_last;

  token_scoreboard sb = new();
  bit              calm = 1'b0;
  bit              drained = 1'b0;
  int              hold_cycles = 0;
  int              idle_cycles = 0;
  int              bytes_sent = 0;
  logic [7:0]      msg_bytes[$];

  msgpack_subset_token_decoder dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_in_message (last_in_message),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .token_kind      (token_kind),
    .token_value     (token_value),
    .payload_byte    (payload_byte),
    .payload_last    (payload_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int payload_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 6);
    return $urandom_range(7, 31);
  endfunction

  // Stall the result channel at random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall   <= 1'b0;
      hold_cycles <= pick_gap();
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.compare_token({token_kind, token_value, payload_byte, payload_last});
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** msgpack_subset_token_decoder: FAILED **");
      $finish;
    end
  end

  // Offer one byte, hold it until accepted, return at the next falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    data_byte       <= b;
    last_in_message <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.decode_byte(b, l);
    @(negedge clk);
  endtask

  // Append one byte to the message under construction
  task automatic append_byte(input logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endtask

  task automatic add_payload(input int len);
    repeat (len) append_byte(8'($urandom_range(0, 255)));
  endtask

  // Append one well-formed token with random content
  task automatic add_token();
    int len;
    len = payload_len();
    case ($urandom_range(0, 11))
      0: append_byte(8'($urandom_range(0, 127)));
      1: append_byte(HB_NIL);
      2: begin
        append_byte(HB_UINT8);
        add_payload(1);
      end
      3: begin
        append_byte(HB_UINT16);
        add_payload(2);
      end
      4: begin
        append_byte(HB_UINT32);
        add_payload(4);
      end
      5: begin
        append_byte(HB_BIN8);
        append_byte(8'(len));
        add_payload(len);
      end
      6: begin
        append_byte(HB_BIN16);
        append_byte(8'd0);
        append_byte(8'(len));
        add_payload(len);
      end
      7: begin
        append_byte(HB_BIN32);
        repeat (3) append_byte(8'd0);
        append_byte(8'(len));
        add_payload(len);
      end
      8: begin
        append_byte(HB_FIXSTR_LO | 8'(len));
        add_payload(len);
      end
      9: begin
        append_byte(HB_STR8);
        append_byte(8'(len));
        add_payload(len);
      end
      10: append_byte(HB_FIXARR_LO | 8'($urandom_range(0, 15)));
      default: begin
        append_byte(HB_ARRAY16);
        add_payload(2);
      end
    endcase
  endtask

  // Build one message: mostly well-formed, the rest cut short, oversized or noise
  task automatic build_message();
    int         r;
    int         cut;
    logic [7:0] b;
    msg_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 80) begin
      repeat ($urandom_range(1, 5)) add_token();
      if (r >= 68 && msg_bytes.size() > 1) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end else if (r < 88) begin
      // Random bin/str length, usually far longer than the bytes that follow
      case ($urandom_range(0, 2))
        0: begin
          append_byte(HB_BIN16);
          add_payload(2);
        end
        1: begin
          append_byte(HB_BIN32);
          add_payload(4);
        end
        default: begin
          append_byte(HB_STR8);
          add_payload(1);
        end
      endcase
      add_payload($urandom_range(1, 4));
    end else if (r < 95) begin
      repeat ($urandom_range(0, 2)) add_token();
      do b = 8'($urandom_range(128, 255));
      while ((b >= HB_FIXARR_LO && b <= HB_FIXSTR_HI) || b == HB_NIL || b == HB_BIN8 ||
             b == HB_BIN16 || b == HB_BIN32 || b == HB_UINT8 || b == HB_UINT16 ||
             b == HB_UINT32 || b == HB_STR8 || b == HB_ARRAY16);
      append_byte(b);
      add_payload($urandom_range(0, 3));
    end else begin
      add_payload($urandom_range(1, 6));
    end
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    bytes_sent += msg_bytes.size();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Field extremes and each error path
    send_byte(8'h00, 1'b1);
    send_byte(HB_FIXINT_HI, 1'b0);
    send_byte(HB_NIL, 1'b1);
    send_byte(HB_UINT32, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(HB_BIN8, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAB, 1'b1);
    // Zero-length str, then the largest fixarray
    send_byte(HB_FIXSTR_LO, 1'b0);
    send_byte(HB_FIXARR_HI, 1'b1);
    // Unknown header and skip to the end of the message
    send_byte(8'hC1, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
    // Unknown header on the final byte
    send_byte(8'hFF, 1'b1);
    // Message ends inside a header
    send_byte(HB_UINT16, 1'b0);
    send_byte(8'h12, 1'b1);
    // Header completes on the final byte with a nonzero length
    send_byte(HB_STR8, 1'b0);
    send_byte(8'h03, 1'b1);
    // Message ends inside a payload
    send_byte(HB_FIXSTR_LO | 8'd3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);

    while (bytes_sent < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 7) == 0);
      build_message();
      send_message();
      // Hold the sender once until every result is back
      if (!drained && bytes_sent >= RANDOM_BYTES / 2) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
        drained = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** msgpack_subset_token_decoder: PASSED **");
    else
      $display("** msgpack_subset_token_decoder: FAILED **");
    $finish;
  end

endmodule
